/* rtl/core/chgs_pkg.sv */
package chgs_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    typedef enum logic [4:0] {
        S_LOAD,
        S_PV_RD,
        S_PV_CMP,
        S_SWAP0,
        S_SWAP1,
        S_SO_T,
        S_SO_TP,
        S_SO_TD,
        S_SO_CHK,
        S_SO_U,
        S_SO_UD,
        S_SO_CMP,
        S_SO_PUT,
        S_SC_A,
        S_SC_B,
        S_SC_C,
        S_SC_D,
        S_SC_R,
        S_SC_RI,
        S_SC_RD,
        S_SC_CHK,
        S_SC_CMP,
        S_SC_S2,
        S_SC_S2D,
        S_SC_PUSH,
        S_EM_IDX,
        S_EM_PT,
        S_EM_OUT,
        S_EM_WAIT
    } t_state;

    // request to the orientation unit
    typedef struct packed {
        logic start;
        logic with_dist;
    } t_orient_ctl;

    // answer from the orientation unit; neg is the sign of the accumulated sum
    typedef struct packed {
        logic done;
        logic neg;
    } t_orient_sts;

endpackage

/* rtl/core/chgs_ram.sv */
module chgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/chgs_orient.sv */
// Shared multiply-accumulate unit. Term order:
//   +(qy-py)(rx-qx)  -(qx-px)(ry-qy)            orientation
//   +(qx-px)^2 +(qy-py)^2 -(rx-px)^2 -(ry-py)^2   distance tie-break
// Stops after the orientation terms unless the sum is zero and with_dist is set.
module chgs_orient
    import chgs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_orient_ctl                  i_ctl,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic signed [COORD_BITS-1:0] i_qx,
    input  logic signed [COORD_BITS-1:0] i_qy,
    input  logic signed [COORD_BITS-1:0] i_rx,
    input  logic signed [COORD_BITS-1:0] i_ry,
    output t_orient_sts                  o_sts
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int AW = 2 * COORD_BITS + 4;

    logic                 r_busy;
    logic                 r_accph;
    logic                 r_with_dist;
    logic [2:0]           r_step;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;
    logic                 r_done;
    logic                 r_neg;

    logic signed [DW-1:0] dqp_x, dqp_y, drq_x, drq_y, drp_x, drp_y;
    logic signed [DW-1:0] op_a, op_b;
    logic                 sub;
    logic signed [AW-1:0] acc_n;
    logic                 last_term;

    assign dqp_x = DW'(i_qx) - DW'(i_px);
    assign dqp_y = DW'(i_qy) - DW'(i_py);
    assign drq_x = DW'(i_rx) - DW'(i_qx);
    assign drq_y = DW'(i_ry) - DW'(i_qy);
    assign drp_x = DW'(i_rx) - DW'(i_px);
    assign drp_y = DW'(i_ry) - DW'(i_py);

    always_comb begin
        case (r_step)
            3'd0: begin op_a = dqp_y; op_b = drq_x; end
            3'd1: begin op_a = dqp_x; op_b = drq_y; end
            3'd2: begin op_a = dqp_x; op_b = dqp_x; end
            3'd3: begin op_a = dqp_y; op_b = dqp_y; end
            3'd4: begin op_a = drp_x; op_b = drp_x; end
            default: begin op_a = drp_y; op_b = drp_y; end
        endcase
    end

    assign sub   = (r_step == 3'd1) || (r_step >= 3'd4);
    assign acc_n = sub ? (r_acc - AW'(r_prod)) : (r_acc + AW'(r_prod));
    assign last_term = ((r_step == 3'd1) && (!r_with_dist || (acc_n != '0)))
                     || (r_step == 3'd5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_accph <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_accph <= 1'b0;
            end else if (r_busy) begin
                r_accph <= !r_accph;
                if (r_accph && last_term) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_step      <= 3'd0;
            r_acc       <= '0;
            r_with_dist <= i_ctl.with_dist;
        end else if (r_busy) begin
            if (!r_accph) begin
                r_prod <= op_a * op_b;
            end else begin
                r_acc  <= acc_n;
                r_neg  <= acc_n[AW-1];
                r_step <= r_step + 3'd1;
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.neg  = r_neg;

endmodule

/* rtl/core/convex_hull_graham_scan_core.sv */
// Graham-scan convex hull. Points arrive one per transfer on s_axis ({y, x} in
// tdata, tlast on the final point); up to MAX_POINTS are kept, later ones are
// dropped and tuser is raised on every vertex of that set. After the final
// point the block stops accepting: the pivot search reads and compares each
// point in turn, then an insertion sort by angle and the stack scan follow,
// every comparison running on one shared multiply-accumulate unit (with the
// distance tie-break when the sort meets collinear points) after memory reads
// of its operands; the sort costs up to n*n/2 comparisons. Each hull vertex is
// read back through the order list and held on m_axis until it is taken. Sets
// of fewer than three points come out unchanged in load order.
module convex_hull_graham_scan_core
    import chgs_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // point_x, point_y, zero pad
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // final_point
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // vertex_x, vertex_y, zero pad
    output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_axis_tdata,
    // final_vertex
    output logic                                  m_axis_tlast,
    // overflowed
    output logic                                  m_axis_tuser
);

    localparam int DATA_W = ((2*COORD_BITS+7)/8)*8;
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int PT_W   = 2 * COORD_BITS;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt, r_i, n_i, r_j, n_j, r_d, n_d, r_k, n_k;
    logic r_drop, n_drop;
    logic [IDX_W-1:0] r_piv, n_piv, r_t, n_t, r_u, n_u, r_ri, n_ri;
    logic signed [COORD_BITS-1:0] r_px, n_px, r_py, n_py, r_qx, n_qx, r_qy, n_qy;
    logic signed [COORD_BITS-1:0] r_rx, n_rx, r_ry, n_ry, r_vx, n_vx, r_vy, n_vy;
    logic r_ovalid, n_ovalid, r_vlast, n_vlast, r_vuser, n_vuser;

    logic             pt_we;
    logic [IDX_W-1:0] pt_waddr, pt_raddr;
    logic [PT_W-1:0]  pt_wdata, pt_rdata;
    logic             ord_we;
    logic [IDX_W-1:0] ord_waddr, ord_raddr, ord_wdata, ord_rdata;

    logic signed [COORD_BITS-1:0] rd_x, rd_y;
    logic [CNT_W-1:0] cnt_last, cnt_inc;

    t_orient_ctl orient_ctl;
    t_orient_sts orient_sts;

    assign rd_x     = pt_rdata[COORD_BITS-1:0];
    assign rd_y     = pt_rdata[PT_W-1:COORD_BITS];
    assign cnt_last = r_cnt - CNT_W'(1);
    assign cnt_inc  = (r_cnt < MAX_CNT) ? r_cnt + CNT_W'(1) : r_cnt;

    chgs_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (pt_waddr),
        .i_wdata (pt_wdata),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    // order list; the hull stack is built in place over its front
    chgs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    chgs_orient #(.COORD_BITS(COORD_BITS)) u_orient (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (orient_ctl),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .i_rx    (r_rx),
        .i_ry    (r_ry),
        .o_sts   (orient_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_d      <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_d      <= n_d;
            r_drop   <= n_drop;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_piv   <= n_piv;
        r_t     <= n_t;
        r_u     <= n_u;
        r_ri    <= n_ri;
        r_px    <= n_px;
        r_py    <= n_py;
        r_qx    <= n_qx;
        r_qy    <= n_qy;
        r_rx    <= n_rx;
        r_ry    <= n_ry;
        r_vx    <= n_vx;
        r_vy    <= n_vy;
        r_vlast <= n_vlast;
        r_vuser <= n_vuser;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_i      = r_i;
        n_j      = r_j;
        n_d      = r_d;
        n_k      = r_k;
        n_drop   = r_drop;
        n_piv    = r_piv;
        n_t      = r_t;
        n_u      = r_u;
        n_ri     = r_ri;
        n_px     = r_px;
        n_py     = r_py;
        n_qx     = r_qx;
        n_qy     = r_qy;
        n_rx     = r_rx;
        n_ry     = r_ry;
        n_ovalid = r_ovalid;
        n_vx     = r_vx;
        n_vy     = r_vy;
        n_vlast  = r_vlast;
        n_vuser  = r_vuser;

        pt_we      = 1'b0;
        pt_waddr   = r_cnt[IDX_W-1:0];
        pt_wdata   = s_axis_tdata[PT_W-1:0];
        pt_raddr   = ord_rdata;
        ord_we     = 1'b0;
        ord_waddr  = r_cnt[IDX_W-1:0];
        ord_wdata  = r_cnt[IDX_W-1:0];
        ord_raddr  = r_i[IDX_W-1:0];
        orient_ctl = '0;

        case (r_state)
            S_LOAD: begin
                if (s_axis_tvalid) begin
                    if (r_cnt < MAX_CNT) begin
                        pt_we  = 1'b1;
                        ord_we = 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    n_cnt = cnt_inc;
                    if (s_axis_tlast) begin
                        n_i = '0;
                        n_k = '0;
                        if (cnt_inc < CNT_W'(3)) begin
                            n_d     = cnt_inc;
                            n_state = S_EM_IDX;
                        end else begin
                            n_state = S_PV_RD;
                        end
                    end
                end
            end
            S_PV_RD: begin
                pt_raddr = r_i[IDX_W-1:0];
                n_state  = S_PV_CMP;
            end
            S_PV_CMP: begin
                if ((r_i == '0) || (rd_y < r_py) || ((rd_y == r_py) && (rd_x < r_px))) begin
                    n_px  = rd_x;
                    n_py  = rd_y;
                    n_piv = r_i[IDX_W-1:0];
                end
                if (r_i == cnt_last) begin
                    n_state = S_SWAP0;
                end else begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = S_PV_RD;
                end
            end
            S_SWAP0: begin
                ord_we    = 1'b1;
                ord_waddr = '0;
                ord_wdata = r_piv;
                n_state   = S_SWAP1;
            end
            S_SWAP1: begin
                if (r_piv != '0) begin
                    ord_we = 1'b1;
                end
                ord_waddr = r_piv;
                ord_wdata = '0;
                n_i       = CNT_W'(2);
                n_state   = S_SO_T;
            end
            S_SO_T: begin
                ord_raddr = r_i[IDX_W-1:0];
                n_state   = S_SO_TP;
            end
            S_SO_TP: begin
                n_t     = ord_rdata;
                n_j     = r_i;
                n_state = S_SO_TD;
            end
            S_SO_TD: begin
                n_qx    = rd_x;
                n_qy    = rd_y;
                n_state = S_SO_CHK;
            end
            S_SO_CHK: begin
                ord_raddr = IDX_W'(r_j - CNT_W'(1));
                n_state   = (r_j > CNT_W'(1)) ? S_SO_U : S_SO_PUT;
            end
            S_SO_U: begin
                n_u     = ord_rdata;
                n_state = S_SO_UD;
            end
            S_SO_UD: begin
                n_rx                 = rd_x;
                n_ry                 = rd_y;
                orient_ctl.start     = 1'b1;
                orient_ctl.with_dist = 1'b1;
                n_state              = S_SO_CMP;
            end
            S_SO_CMP: begin
                if (orient_sts.done) begin
                    if (orient_sts.neg) begin
                        ord_we    = 1'b1;
                        ord_waddr = r_j[IDX_W-1:0];
                        ord_wdata = r_u;
                        n_j       = r_j - CNT_W'(1);
                        n_state   = S_SO_CHK;
                    end else begin
                        n_state = S_SO_PUT;
                    end
                end
            end
            S_SO_PUT: begin
                ord_we    = 1'b1;
                ord_waddr = r_j[IDX_W-1:0];
                ord_wdata = r_t;
                if (r_i == cnt_last) begin
                    n_state = S_SC_A;
                end else begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = S_SO_T;
                end
            end
            S_SC_A: begin
                ord_raddr = IDX_W'(1);
                n_state   = S_SC_B;
            end
            S_SC_B: begin
                ord_raddr = IDX_W'(2);
                n_state   = S_SC_C;
            end
            S_SC_C: begin
                n_px    = rd_x;
                n_py    = rd_y;
                n_state = S_SC_D;
            end
            S_SC_D: begin
                n_qx = rd_x;
                n_qy = rd_y;
                n_d  = CNT_W'(3);
                n_i  = CNT_W'(3);
                n_k  = '0;
                n_state = (r_cnt == CNT_W'(3)) ? S_EM_IDX : S_SC_R;
            end
            S_SC_R: begin
                ord_raddr = r_i[IDX_W-1:0];
                n_state   = S_SC_RI;
            end
            S_SC_RI: begin
                n_ri    = ord_rdata;
                n_state = S_SC_RD;
            end
            S_SC_RD: begin
                n_rx    = rd_x;
                n_ry    = rd_y;
                n_state = S_SC_CHK;
            end
            S_SC_CHK: begin
                if (r_d > CNT_W'(2)) begin
                    orient_ctl.start = 1'b1;
                    n_state          = S_SC_CMP;
                end else begin
                    n_state = S_SC_PUSH;
                end
            end
            S_SC_CMP: begin
                // pop on a clockwise or collinear turn
                ord_raddr = IDX_W'(r_d - CNT_W'(3));
                if (orient_sts.done) begin
                    if (!orient_sts.neg) begin
                        n_d     = r_d - CNT_W'(1);
                        n_qx    = r_px;
                        n_qy    = r_py;
                        n_state = S_SC_S2;
                    end else begin
                        n_state = S_SC_PUSH;
                    end
                end
            end
            S_SC_S2: begin
                n_state = S_SC_S2D;
            end
            S_SC_S2D: begin
                n_px    = rd_x;
                n_py    = rd_y;
                n_state = S_SC_CHK;
            end
            S_SC_PUSH: begin
                ord_we    = 1'b1;
                ord_waddr = r_d[IDX_W-1:0];
                ord_wdata = r_ri;
                n_d       = r_d + CNT_W'(1);
                n_px      = r_qx;
                n_py      = r_qy;
                n_qx      = r_rx;
                n_qy      = r_ry;
                n_k       = '0;
                if (r_i == cnt_last) begin
                    n_state = S_EM_IDX;
                end else begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = S_SC_R;
                end
            end
            S_EM_IDX: begin
                ord_raddr = r_k[IDX_W-1:0];
                n_state   = S_EM_PT;
            end
            S_EM_PT: begin
                n_state = S_EM_OUT;
            end
            S_EM_OUT: begin
                n_ovalid = 1'b1;
                n_vx     = rd_x;
                n_vy     = rd_y;
                n_vlast  = (r_k + CNT_W'(1) == r_d);
                n_vuser  = r_drop;
                n_state  = S_EM_WAIT;
            end
            S_EM_WAIT: begin
                if (m_axis_tready) begin
                    n_ovalid = 1'b0;
                    if (r_vlast) begin
                        n_cnt   = '0;
                        n_d     = '0;
                        n_drop  = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + CNT_W'(1);
                        n_state = S_EM_IDX;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_LOAD);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = DATA_W'({r_vy, r_vx});
    assign m_axis_tlast  = r_vlast;
    assign m_axis_tuser  = r_vuser;

endmodule

/* rtl/core/chgs_chk.sv */
module chgs_chk #(
    parameter int DATA_W = 32
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              s_axis_tlast,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic              m_axis_tlast,
    input logic              m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // no loading while a hull is being emitted
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a vertex is pending");

    // a point without tlast keeps the loader open
    a_keep_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
        else $error("loader closed before the final point");

    // after the last vertex the block is back to loading
    a_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
        else $error("no return to loading after the last vertex");

endmodule

bind convex_hull_graham_scan_core chgs_chk #(.DATA_W(DATA_W)) u_chgs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

/* tb/sv/convex_hull_graham_scan_core_tb.sv */
`timescale 1ns / 1ps

module convex_hull_graham_scan_core_tb;
    import chgs_pkg::*;

    localparam int NPTS   = MAX_POINTS_DEF;
    localparam int CB     = COORD_BITS_DEF;
    localparam int DW     = ((2*CB+7)/8)*8;
    localparam int LIMIT  = 4000000;

    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 fin;
    } t_point;

    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 fin;
        logic                 ovf;
    } t_vertex;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [DW-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic m_axis_tuser;

    convex_hull_graham_scan_core dut (.*);

    always #6 i_clk = ~i_clk;

    // hull model state
    longint px[NPTS];
    longint py[NPTS];
    int     n_held;
    bit     dropped;

    t_vertex hull_q[$];
    t_vertex typed_q[$];
    t_point  pts[$];
    bit      failed = 1'b0;
    bit      stim_done = 1'b0;
    longint  cyc = 0;

    function automatic int orient(int p, int q, int r);
        longint v;
        v = (py[q] - py[p]) * (px[r] - px[q]) - (px[q] - px[p]) * (py[r] - py[q]);
        if (v == 0) return 0;
        return (v > 0) ? 1 : 2;
    endfunction

    function automatic longint d2(int a, int b);
        return (px[a]-px[b])*(px[a]-px[b]) + (py[a]-py[b])*(py[a]-py[b]);
    endfunction

    function automatic bit ahead(int p, int a, int b);
        int o;
        o = orient(p, a, b);
        if (o == 0) return d2(p, a) < d2(p, b);
        return o == 2;
    endfunction

    task automatic add_vertex(int idx, bit last);
        t_vertex v;
        v.x = CB'(px[idx]); v.y = CB'(py[idx]); v.fin = last; v.ovf = dropped;
        if (typed_q.size() > 0) begin
            v = typed_q.pop_front();
        end
        hull_q = {hull_q, v};
    endtask

    task automatic predict_hull(t_point p);
        int ord[NPTS];
        int stk[NPTS];
        int n, piv, t, j, sp;
        if (n_held < NPTS) begin
            px[n_held] = longint'(p.x); py[n_held] = longint'(p.y); n_held++;
        end else begin
            dropped = 1'b1;
        end
        if (!p.fin) return;
        n = n_held;
        if (n < 3) begin
            for (int i = 0; i < n; i++) add_vertex(i, i+1 == n);
        end else begin
            for (int i = 0; i < n; i++) ord[i] = i;
            piv = 0;
            for (int i = 1; i < n; i++)
                if (py[i] < py[piv] || (py[i] == py[piv] && px[i] < px[piv])) piv = i;
            ord[0] = piv; ord[piv] = 0;
            for (int i = 2; i < n; i++) begin
                t = ord[i]; j = i;
                while (j > 1 && ahead(piv, t, ord[j-1])) begin
                    ord[j] = ord[j-1]; j--;
                end
                ord[j] = t;
            end
            sp = 0;
            for (int i = 0; i < 3; i++) stk[sp++] = ord[i];
            for (int i = 3; i < n; i++) begin
                while (sp > 2 && orient(stk[sp-2], stk[sp-1], ord[i]) != 2) sp--;
                stk[sp++] = ord[i];
            end
            for (int i = 0; i < sp; i++) add_vertex(stk[i], i+1 == sp);
        end
        n_held = 0;
        dropped = 1'b0;
    endtask

    function automatic t_point mk(int x, int y, bit f);
        t_point p;
        p.x = CB'(x); p.y = CB'(y); p.fin = f;
        return p;
    endfunction

    function automatic t_point rnd_pt(bit f, int span);
        t_point p;
        if (span == 0) begin
            p.x = CB'($urandom); p.y = CB'($urandom);
        end else begin
            p.x = CB'(int'($urandom_range(2*span)) - span);
            p.y = CB'(int'($urandom_range(2*span)) - span);
        end
        p.fin = f;
        return p;
    endfunction

    // sender
    initial begin : drive
        t_point p;
        int gap, n, span;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single point, pair, extremes, square with collinear and duplicate points
        pts = {pts, mk(-32768, 32767, 1)};
        pts = {pts, mk(32767, -32768, 0)};
        pts = {pts, mk(-1, -1, 1)};
        pts = {pts, mk(0, 0, 0)};
        pts = {pts, mk(4, 0, 0)};
        pts = {pts, mk(2, 0, 0)};
        pts = {pts, mk(4, 4, 0)};
        pts = {pts, mk(0, 4, 0)};
        pts = {pts, mk(2, 2, 0)};
        pts = {pts, mk(4, 4, 1)};
        pts = {pts, mk(-32768, -32768, 0)};
        pts = {pts, mk(32767, -32768, 0)};
        pts = {pts, mk(32767, 32767, 0)};
        pts = {pts, mk(-32768, 32767, 1)};
        pts = {pts, mk(5, 5, 0)};
        pts = {pts, mk(5, 5, 0)};
        pts = {pts, mk(5, 5, 1)};
        pts = {pts, mk(1, 1, 0)};
        pts = {pts, mk(2, 2, 0)};
        pts = {pts, mk(3, 3, 1)};

        // random sets; one overflowing set
        while (pts.size() < 88) begin
            n = $urandom_range(1, 12);
            span = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
            for (int i = 0; i < n; i++) pts = {pts, rnd_pt(i == n-1, span)};
        end
        for (int i = 0; i < NPTS + 3; i++) pts = {pts, rnd_pt(i == NPTS + 2, 0)};
        for (int i = 0; i < 5; i++) pts = {pts, rnd_pt(i == 4, 100)};

        foreach (pts[k]) begin
            p = pts[k];
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(7);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= DW'({p.y, p.x});
            s_axis_tlast  <= p.fin;
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            predict_hull(p);
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // directed expectations typed in: lone point at the extremes, pair
    initial begin
        t_vertex v;
        v.x = CB'(-32768); v.y = CB'(32767); v.fin = 1'b1; v.ovf = 1'b0;
        typed_q = {typed_q, v};
        v.x = CB'(32767); v.y = CB'(-32768); v.fin = 1'b0;
        typed_q = {typed_q, v};
        v.x = CB'(-1); v.y = CB'(-1); v.fin = 1'b1;
        typed_q = {typed_q, v};
    end

    // receiver
    int stall = 0;
    always @(posedge i_clk) begin
        t_vertex e;
        logic signed [CB-1:0] ax, ay;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                ax = m_axis_tdata[CB-1:0];
                ay = m_axis_tdata[2*CB-1:CB];
                if (hull_q.size() == 0) begin
                    $display("%0t: unexpected vertex x=%0d y=%0d", $time, ax, ay);
                    failed = 1'b1;
                end else begin
                    e = hull_q.pop_front();
                    if (ax !== e.x || ay !== e.y || m_axis_tlast !== e.fin
                        || m_axis_tuser !== e.ovf) begin
                        $display("%0t: expected x=%0d y=%0d last=%0b ovf=%0b, got x=%0d y=%0d last=%0b ovf=%0b",
                                 $time, e.x, e.y, e.fin, e.ovf, ax, ay, m_axis_tlast,
                                 m_axis_tuser);
                        failed = 1'b1;
                    end
                end
                stall = $urandom_range(1) ? 0 : $urandom_range(7);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : finish_run
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc > LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
            if (stim_done && hull_q.size() == 0) disable finish_run;
        end
    end

    initial begin
        wait (stim_done && hull_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (!failed && hull_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* convex_hull_graham_scan_core.f */
rtl/core/chgs_pkg.sv
rtl/core/chgs_ram.sv
rtl/core/chgs_orient.sv
rtl/core/convex_hull_graham_scan_core.sv
rtl/core/chgs_chk.sv
tb/sv/convex_hull_graham_scan_core_tb.sv
